>>> rtl/pkht_pkg.sv
// Shared types and constants of the process id hash table.
package pkht_pkg;

  // Field widths of one item.
  localparam int unsigned OpW   = 2;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned TimeW = 64;
  localparam int unsigned HdlW  = 32;
  localparam int unsigned StW   = 2;

  // Key bits folded into the bucket remainder per hashing step.
  localparam int unsigned HashBits  = 8;
  localparam int unsigned HashSteps = KeyW / HashBits;

  // Operation codes.
  localparam logic [OpW-1:0] OP_ADD  = 2'd0;
  localparam logic [OpW-1:0] OP_DEL  = 2'd1;
  localparam logic [OpW-1:0] OP_FIND = 2'd2;

  // Status codes.
  localparam logic [StW-1:0] ST_OK        = 2'd0;
  localparam logic [StW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StW-1:0] ST_FULL      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // clear the valid bits of one bucket row
    logic accept;     // capture a request (and read its row when no hashing is needed)
    logic hash_step;  // fold the next key bits into the bucket remainder
    logic rd_issue;   // read the bucket row at the computed bucket
    logic exec;       // write the row back and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // the clear pass is on its last row
    logic hash_last;  // the bucket remainder is complete after this step
    logic out_free;   // the result register can take a new item
  } dp_sts_t;

endpackage

>>> rtl/pkht_req_if.sv
// Request channel: valid/ready handshake with one operation per item.
interface pkht_req_if;
  logic                          valid;
  logic                          ready;
  logic [pkht_pkg::OpW-1:0]      operation;
  logic [pkht_pkg::KeyW-1:0]     process_id;
  logic [pkht_pkg::TimeW-1:0]    seen_time;
  logic [pkht_pkg::HdlW-1:0]     info_handle;

  modport source (output valid, operation, process_id, seen_time, info_handle, input ready);
  modport sink   (input valid, operation, process_id, seen_time, info_handle, output ready);
endinterface

>>> rtl/pkht_rsp_if.sv
// Response channel: valid/ready handshake with one result per item.
interface pkht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pkht_pkg::StW-1:0]      status;
  logic                          hit;
  logic [pkht_pkg::TimeW-1:0]    time_out;
  logic [pkht_pkg::HdlW-1:0]     handle_out;

  modport source (output valid, status, hit, time_out, handle_out, input ready);
  modport sink   (input valid, status, hit, time_out, handle_out, output ready);
endinterface

>>> rtl/pkht_ctrl.sv
// Controller state machine of the process id hash table.
module pkht_ctrl #(
  parameter bit USE_HASH = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  pkht_pkg::dp_sts_t sts_i,
  output pkht_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_EXEC  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = USE_HASH ? S_HASH : S_EXEC;
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/pkht_datapath.sv
// Datapath: bucket memories, bucket hashing, way compare and result register.
module pkht_datapath #(
  parameter int unsigned BUCKETS = 2048,
  parameter int unsigned WAYS    = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pkht_pkg::dp_cmd_t             cmd_i,
  output pkht_pkg::dp_sts_t             sts_o,
  input  logic [pkht_pkg::OpW-1:0]      operation_i,
  input  logic [pkht_pkg::KeyW-1:0]     process_id_i,
  input  logic [pkht_pkg::TimeW-1:0]    seen_time_i,
  input  logic [pkht_pkg::HdlW-1:0]     info_handle_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [pkht_pkg::StW-1:0]      status_o,
  output logic                          hit_o,
  output logic [pkht_pkg::TimeW-1:0]    time_out_o,
  output logic [pkht_pkg::HdlW-1:0]     handle_out_o
);

  localparam int unsigned BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit          UseHash = (BUCKETS & (BUCKETS - 1)) != 0;

  // Bucket row memories, one entry per way in each row.
  logic [WAYS-1:0]                          vld_mem  [BUCKETS];
  logic [WAYS-1:0][pkht_pkg::KeyW-1:0]      key_mem  [BUCKETS];
  logic [WAYS-1:0][pkht_pkg::TimeW-1:0]     time_mem [BUCKETS];
  logic [WAYS-1:0][pkht_pkg::HdlW-1:0]      hdl_mem  [BUCKETS];

  logic [WAYS-1:0]                          vld_rd_q;
  logic [WAYS-1:0][pkht_pkg::KeyW-1:0]      key_rd_q;
  logic [WAYS-1:0][pkht_pkg::TimeW-1:0]     time_rd_q;
  logic [WAYS-1:0][pkht_pkg::HdlW-1:0]      hdl_rd_q;

  logic [WAYS-1:0]                          vld_wr;
  logic [WAYS-1:0][pkht_pkg::KeyW-1:0]      key_wr;
  logic [WAYS-1:0][pkht_pkg::TimeW-1:0]     time_wr;
  logic [WAYS-1:0][pkht_pkg::HdlW-1:0]      hdl_wr;

  // Captured request.
  logic [pkht_pkg::OpW-1:0]   op_q;
  logic [pkht_pkg::KeyW-1:0]  key_q;
  logic [pkht_pkg::TimeW-1:0] time_q;
  logic [pkht_pkg::HdlW-1:0]  hdl_q;

  logic [BW-1:0] clr_cnt_q;
  logic [BW-1:0] in_bkt;
  logic [BW-1:0] bucket;
  logic [BW-1:0] rd_addr;
  logic [BW-1:0] wr_addr;
  logic          rd_en;
  logic          hash_last;

  // Result register.
  logic                       rsp_valid_q;
  logic [pkht_pkg::StW-1:0]   status_q, status_d;
  logic                       hit_q, hit_d;
  logic [pkht_pkg::TimeW-1:0] tout_q, tout_d;
  logic [pkht_pkg::HdlW-1:0]  hout_q, hout_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      key_q  <= process_id_i;
      time_q <= seen_time_i;
      hdl_q  <= info_handle_i;
    end
  end

  // Bucket selection: low key bits for a power-of-two bucket count,
  // otherwise a remainder built HashBits key bits per hashing step.
  if (UseHash) begin : g_hash
    localparam int unsigned RW = BW + 1;
    localparam int unsigned CW = (pkht_pkg::HashSteps > 1) ? $clog2(pkht_pkg::HashSteps) : 1;

    logic [BW-1:0]             rem_q, rem_d;
    logic [pkht_pkg::KeyW-1:0] sh_q, sh_d;
    logic [CW-1:0]             cnt_q;

    always_comb begin
      logic [RW-1:0]             r;
      logic [pkht_pkg::KeyW-1:0] s;
      r = {1'b0, rem_q};
      s = sh_q;
      for (int i = 0; i < int'(pkht_pkg::HashBits); i++) begin
        r = {r[RW-2:0], s[pkht_pkg::KeyW-1]};
        s = {s[pkht_pkg::KeyW-2:0], 1'b0};
        if (r >= RW'(BUCKETS)) begin
          r = r - RW'(BUCKETS);
        end
      end
      rem_d = r[BW-1:0];
      sh_d  = s;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q <= '0;
      end else if (cmd_i.accept) begin
        cnt_q <= '0;
      end else if (cmd_i.hash_step) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) begin
        rem_q <= '0;
        sh_q  <= process_id_i;
      end else if (cmd_i.hash_step) begin
        rem_q <= rem_d;
        sh_q  <= sh_d;
      end
    end

    assign hash_last = (cnt_q == CW'(pkht_pkg::HashSteps - 1));
    assign in_bkt    = '0;
    assign bucket    = rem_q;
  end else begin : g_direct
    logic [BW-1:0] bkt_q;

    if (BUCKETS == 1) begin : g_one
      assign in_bkt = '0;
    end else begin : g_bits
      assign in_bkt = process_id_i[BW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) begin
        bkt_q <= in_bkt;
      end
    end

    assign hash_last = 1'b1;
    assign bucket    = bkt_q;
  end

  // Clear pass over all bucket rows after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + BW'(1);
    end
  end

  assign rd_en   = (cmd_i.accept && !UseHash) || cmd_i.rd_issue;
  assign rd_addr = cmd_i.rd_issue ? bucket : in_bkt;
  assign wr_addr = cmd_i.clr_step ? clr_cnt_q : bucket;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      vld_mem[wr_addr] <= '0;
    end else if (cmd_i.exec) begin
      vld_mem[wr_addr] <= vld_wr;
    end
    if (rd_en) begin
      vld_rd_q <= vld_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      key_mem[wr_addr]  <= key_wr;
      time_mem[wr_addr] <= time_wr;
      hdl_mem[wr_addr]  <= hdl_wr;
    end
    if (rd_en) begin
      key_rd_q  <= key_mem[rd_addr];
      time_rd_q <= time_mem[rd_addr];
      hdl_rd_q  <= hdl_mem[rd_addr];
    end
  end

  // Way compare and row update.
  always_comb begin
    logic [WAYS-1:0] match;
    logic            present;
    logic            any_free;
    logic [WW-1:0]   m_idx;
    logic [WW-1:0]   f_idx;
    logic [WW-1:0]   tgt;

    match    = '0;
    present  = 1'b0;
    any_free = 1'b0;
    m_idx    = '0;
    f_idx    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = vld_rd_q[w] && (key_rd_q[w] == key_q);
      if (match[w]) begin
        m_idx = WW'(w);
      end
      if (!vld_rd_q[w]) begin
        f_idx = WW'(w);
      end
    end
    present  = |match;
    any_free = ~&vld_rd_q;
    tgt      = present ? m_idx : f_idx;

    vld_wr   = vld_rd_q;
    key_wr   = key_rd_q;
    time_wr  = time_rd_q;
    hdl_wr   = hdl_rd_q;
    status_d = pkht_pkg::ST_NOT_FOUND;
    hit_d    = 1'b0;
    tout_d   = '0;
    hout_d   = '0;

    case (op_q)
      pkht_pkg::OP_ADD: begin
        hit_d = present;
        if (present || any_free) begin
          vld_wr[tgt]  = 1'b1;
          key_wr[tgt]  = key_q;
          time_wr[tgt] = time_q;
          hdl_wr[tgt]  = hdl_q;
          status_d     = pkht_pkg::ST_OK;
        end else begin
          status_d = pkht_pkg::ST_FULL;
        end
      end
      pkht_pkg::OP_DEL: begin
        hit_d = present;
        if (present) begin
          vld_wr[m_idx] = 1'b0;
          status_d      = pkht_pkg::ST_OK;
        end
      end
      pkht_pkg::OP_FIND: begin
        hit_d = present;
        if (present) begin
          tout_d   = time_rd_q[m_idx];
          hout_d   = hdl_rd_q[m_idx];
          status_d = pkht_pkg::ST_OK;
        end
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      hit_q    <= hit_d;
      tout_q   <= tout_d;
      hout_q   <= hout_d;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign status_o     = status_q;
  assign hit_o        = hit_q;
  assign time_out_o   = tout_q;
  assign handle_out_o = hout_q;

  assign sts_o.clr_last  = (clr_cnt_q == BW'(BUCKETS - 1));
  assign sts_o.hash_last = hash_last;
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

endmodule

>>> rtl/pid_keyed_hash_table.sv
// Top level of the set-associative process table keyed by process id.
//
//   Channel  Direction  Payload                                         Handshake
//   req_i    in         operation, process_id, seen_time, info_handle   valid/ready
//   rsp_o    out        status, hit, time_out, handle_out               valid/ready
//
// With a power-of-two BUCKETS the accept cycle reads the bucket row, and the
// EXEC state then compares all ways, writes the row back and loads the
// result register. Other BUCKETS add the HASH steps and a READ state first.
// After reset the valid bits are cleared one row per cycle, over all BUCKETS
// rows, before the first item is accepted. A result waits in its output register
// while the next item is accepted; only the write-back stalls on a full one.
module pid_keyed_hash_table #(
  parameter int unsigned BUCKETS = 2048,
  parameter int unsigned WAYS    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pkht_req_if.sink          req_i,
  pkht_rsp_if.source        rsp_o
);

  // The bucket index needs a real remainder only when BUCKETS is not a power of two.
  localparam bit UseHash = (BUCKETS & (BUCKETS - 1)) != 0;

  pkht_pkg::dp_cmd_t cmd;
  pkht_pkg::dp_sts_t sts;

  // The controller sequences clear, accept, hashing, read and write-back.
  pkht_ctrl #(
    .USE_HASH (UseHash)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the row memories, the way compare and the result register.
  pkht_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (req_i.operation),
    .process_id_i  (req_i.process_id),
    .seen_time_i   (req_i.seen_time),
    .info_handle_i (req_i.info_handle),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .hit_o         (rsp_o.hit),
    .time_out_o    (rsp_o.time_out),
    .handle_out_o  (rsp_o.handle_out)
  );

endmodule
